@@ rtl/fr_pkg.sv @@
// fr_pkg: shared types and constants for the fraction reducer.
// Item structs, divider operand selection, controller command/status groups.
// No dependencies.
package fr_pkg;

    localparam int DIV_W = 32;
    localparam int CNT_W = $clog2(DIV_W);

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_DIV0 = 1'b1;

    typedef struct packed {
        logic signed [31:0] num_in;
        logic signed [31:0] den_in;
    } in_t;

    typedef struct packed {
        logic signed [32:0] num_out;
        logic [31:0]        den_out;
        logic               status;
    } out_t;

    typedef enum logic [1:0] {
        DIV_EUCLID,
        DIV_NUM,
        DIV_DEN
    } div_op_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        div_op_t div_op;
        logic    euc_update;
        logic    qn_store;
        logic    qd_store;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic y_zero;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/fraction_reducer.sv @@
// fraction_reducer: reduces num/den to lowest terms with a positive denominator.
// The Euclid remainder steps and the two exact divisions all run on the one shared divider,
// so one item is in work at a time; a zero denominator skips the divider. in_ready returns
// the cycle after the result is loaded, and loading waits while the output register is held.
// Reset (rst_n, async) clears the sequencer and output valid.
module fraction_reducer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  fr_pkg::in_t  in_item,
    output logic         out_valid,
    input  logic         out_ready,
    output fr_pkg::out_t out_item
);
    import fr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

@@ rtl/fr_divider.sv @@
// fr_divider: restoring unsigned divider, one quotient bit per cycle.
// Operands latched on start; done is high for a single cycle, registered together with the last bit.
// Depends on fr_pkg.
module fr_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [fr_pkg::DIV_W-1:0] dividend,
    input  logic [fr_pkg::DIV_W-1:0] divisor,
    output logic                     done,
    output logic [fr_pkg::DIV_W-1:0] quotient,
    output logic [fr_pkg::DIV_W-1:0] remainder
);
    import fr_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W+1:0] diff;
    logic             ge;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] quo_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
        diff     = {1'b0, rem_sh} - {2'b00, dvs_reg};
        ge       = ~diff[DIV_W+1];
        rem_next = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && !$past(done_reg)))
        else $error("divider done pulse malformed");

endmodule

@@ rtl/fr_datapath.sv @@
// fr_datapath: operand magnitudes, Euclid registers, quotients and output register.
// Driven by fr_ctrl commands; instantiates fr_divider. Depends on fr_pkg.
module fr_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  fr_pkg::in_t   in_item,
    input  fr_pkg::cmd_t  cmd,
    output fr_pkg::stat_t stat,
    output logic          out_valid,
    input  logic          out_ready,
    output fr_pkg::out_t  out_item
);
    import fr_pkg::*;

    logic [DIV_W-1:0] n_mag_reg;
    logic [DIV_W-1:0] d_mag_reg;
    logic             neg_reg;
    logic             err_reg;
    logic [DIV_W-1:0] x_reg;
    logic [DIV_W-1:0] y_reg;
    logic [DIV_W-1:0] qn_reg;
    logic [DIV_W-1:0] qd_reg;
    out_t             out_reg;
    logic             out_valid_reg;

    logic [DIV_W-1:0] num_u;
    logic [DIV_W-1:0] den_u;
    logic [DIV_W-1:0] n_mag_next;
    logic [DIV_W-1:0] d_mag_next;
    logic [DIV_W-1:0] div_a;
    logic [DIV_W-1:0] div_b;
    logic             div_done;
    logic [DIV_W-1:0] div_q;
    logic [DIV_W-1:0] div_r;
    out_t             out_next;

    always_comb
    begin
        num_u      = in_item.num_in;
        den_u      = in_item.den_in;
        n_mag_next = num_u[DIV_W-1] ? (~num_u + DIV_W'(1)) : num_u;
        d_mag_next = den_u[DIV_W-1] ? (~den_u + DIV_W'(1)) : den_u;
    end

    always_comb
    begin
        case (cmd.div_op)
            DIV_EUCLID:
            begin
                div_a = x_reg;
                div_b = y_reg;
            end
            DIV_NUM:
            begin
                div_a = n_mag_reg;
                div_b = x_reg;
            end
            DIV_DEN:
            begin
                div_a = d_mag_reg;
                div_b = x_reg;
            end
            default:
            begin
                div_a = x_reg;
                div_b = y_reg;
            end
        endcase
    end

    fr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // sign goes onto the numerator; zero numerator stays non-negative
    always_comb
    begin
        if (err_reg)
        begin
            out_next.num_out = '0;
            out_next.den_out = '0;
            out_next.status  = STATUS_DIV0;
        end
        else
        begin
            out_next.num_out = (neg_reg && (qn_reg != '0)) ? (33'sd0 - $signed({1'b0, qn_reg}))
                                                          : $signed({1'b0, qn_reg});
            out_next.den_out = qd_reg;
            out_next.status  = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_mag_reg <= n_mag_next;
            d_mag_reg <= d_mag_next;
            neg_reg   <= num_u[DIV_W-1] ^ den_u[DIV_W-1];
            err_reg   <= (d_mag_next == '0);
            x_reg     <= n_mag_next;
            y_reg     <= d_mag_next;
        end
        else if (cmd.euc_update)
        begin
            x_reg <= y_reg;
            y_reg <= div_r;
        end
        if (cmd.qn_store)
        begin
            qn_reg <= div_q;
        end
        if (cmd.qd_store)
        begin
            qd_reg <= div_q;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.err      = err_reg;
    assign stat.y_zero   = (y_reg == '0);
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start && cmd.div_op != DIV_EUCLID) |-> (x_reg != '0))
        else $error("exact division by zero divisor");

    a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (err_reg == (d_mag_reg == '0)))
        else $error("error flag disagrees with denominator");

endmodule

@@ rtl/fr_ctrl.sv @@
// fr_ctrl: sequencer for Euclid's loop and the two exact divisions.
// Issues fr_pkg::cmd_t to fr_datapath, reads fr_pkg::stat_t. Depends on fr_pkg.
module fr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fr_pkg::stat_t stat,
    output fr_pkg::cmd_t  cmd
);
    import fr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EUC_WAIT,
        S_QN_WAIT,
        S_QD_START,
        S_QD_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.div_start  = 1'b0;
        cmd.div_op     = DIV_EUCLID;
        cmd.euc_update = 1'b0;
        cmd.qn_store   = 1'b0;
        cmd.qd_store   = 1'b0;
        cmd.out_load   = 1'b0;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.err)
                begin
                    state_next = S_OUT;
                end
                else if (stat.y_zero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_NUM;
                    state_next    = S_QN_WAIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_EUCLID;
                    state_next    = S_EUC_WAIT;
                end
            end
            S_EUC_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.euc_update = 1'b1;
                    state_next     = S_CHECK;
                end
            end
            S_QN_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.qn_store = 1'b1;
                    state_next   = S_QD_START;
                end
            end
            S_QD_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_DEN;
                state_next    = S_QD_WAIT;
            end
            S_QD_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.qd_store = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
